// ===== hdl/hekf_pkg.sv =====
// package for the heston variance filter: Q8.24 constants, types, helpers
// no dependencies
package hekf_pkg;

    localparam int QW = 32;
    localparam logic signed [31:0] Q_ONE  = 32'sd16777216;
    localparam logic signed [31:0] Q_HALF = 32'sd8388608;
    localparam logic signed [31:0] Q_DT   = 32'sd66576;
    localparam logic signed [31:0] Q_EPS  = 32'sd168;
    localparam logic signed [31:0] Q_VAR0 = 32'sd671089;
    localparam logic signed [31:0] Q_P0   = 32'sd167772;
    localparam logic signed [31:0] Q_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN  = 32'sh80000000;

    // register indexes
    localparam logic [2:0] REG_DRIFT = 3'd0;
    localparam logic [2:0] REG_OMEGA = 3'd1;
    localparam logic [2:0] REG_THETA = 3'd2;
    localparam logic [2:0] REG_XI    = 3'd3;
    localparam logic [2:0] REG_RHO   = 3'd4;

    // alu operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB
    } alu_op_t;

    // top state machine
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_OUT1,
        ST_OUT2
    } state_t;

    // divider request / status
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    // saturate a 64-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007fffffff) begin
            r = Q_MAX;
        end else if (v < -64'sh0000000080000000) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/heston_ekf_variance_filter.sv =====
// top level of the heston variance filter: registers, sequencer, result register
// depends on hekf_pkg, hekf_alu, hekf_div
//
// channel   dir  transfer when              fields
// s_axis    in   s_tvalid & s_tready        tdata: log_price[31:0]; tlast: last_sample
// m_axis    out  m_tvalid & m_tready        tdata: row_estimate, innovation, variance
// apb       in   psel&penable&pwrite        five parameter registers at 4*i
//
// a first sample has its result registered in the cycle after the transfer; an unmarked
// second sample gives none and the next transfer can follow at once. a filter step runs 42
// shared alu steps; the bit-serial divider starts at step 31 and the sequencer waits for
// it in ST_DIV after step 35; the row is registered when the step has run to its end.
// s_tready is low while an item is at work or a result waits; a marked sample with a
// full step gives two results. reset is synchronous on aresetn and restores the
// filter state and registers.
module heston_ekf_variance_filter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // log_price[31:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // row_estimate[31:0], innovation[63:32], var[94:64]
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hekf_pkg::*;

    // configuration registers
    logic signed [31:0] drift_reg, omega_reg, theta_reg, xi_reg;
    logic signed [25:0] rho_reg;
    logic [2:0] ridx;
    assign ridx   = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drift_reg <= '0; omega_reg <= '0; theta_reg <= '0;
            xi_reg <= '0; rho_reg <= '0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (ridx)
                REG_DRIFT: drift_reg <= pwdata;
                REG_OMEGA: omega_reg <= pwdata;
                REG_THETA: theta_reg <= pwdata;
                REG_XI:    xi_reg    <= pwdata;
                REG_RHO:   rho_reg   <= pwdata[25:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_DRIFT: prdata = drift_reg;
            REG_OMEGA: prdata = omega_reg;
            REG_THETA: prdata = theta_reg;
            REG_XI:    prdata = xi_reg;
            REG_RHO:   prdata = 32'(rho_reg);
            default:   prdata = '0;
        endcase
    end

    logic signed [31:0] rho32;
    assign rho32 = 32'(rho_reg);

    // filter state
    logic signed [31:0] xv_reg, pv_reg, prev_reg, old_reg, pend_reg, z_reg;
    logic [1:0] phase_reg;
    logic       last_reg;
    state_t     state_reg, state_next;
    logic [5:0] pc_reg, pc_next;

    // scratch registers of the step
    logic signed [31:0] x_reg, rx_reg, kr_reg, x1_reg, a_reg, omr_reg, t_reg, t2_reg;
    logic signed [31:0] p1_reg, h_reg, s_reg, k_reg, est_reg, u_reg;

    // shared units
    alu_op_t            op;
    logic signed [31:0] aa, bb, y;
    div_req_t           dreq;
    div_rsp_t           drsp;

    hekf_alu u_alu (.aclk(aclk), .op(op), .a(aa), .b(bb), .y(y));
    hekf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // result register
    logic [95:0] od_reg;
    logic        ol_reg, ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;

    logic in_fire;
    assign in_fire = s_tvalid && s_tready;

    // micro-program: each step issues one alu op; the registered result is taken by the next step
    // operand select for step pc
    always_comb begin
        op = OP_MUL; aa = '0; bb = '0;
        case (pc_reg)
            6'd0:  begin op = OP_MUL; aa = rho32;     bb = xi_reg;    end // rx
            6'd1:  begin op = OP_MUL; aa = Q_HALF;    bb = y;         end // .5rx
            6'd2:  begin op = OP_SUB; aa = theta_reg; bb = y;         end // kr
            6'd3:  begin op = OP_MUL; aa = rx_reg;    bb = drift_reg; end
            6'd4:  begin op = OP_SUB; aa = omega_reg; bb = y;         end
            6'd5:  begin op = OP_MUL; aa = kr_reg;    bb = x_reg;     end
            6'd6:  begin op = OP_SUB; aa = t_reg;     bb = y;         end
            6'd7:  begin op = OP_MUL; aa = y;         bb = Q_DT;      end
            6'd8:  begin op = OP_ADD; aa = x_reg;     bb = y;         end
            6'd9:  begin op = OP_SUB; aa = prev_reg;  bb = old_reg;   end
            6'd10: begin op = OP_MUL; aa = rx_reg;    bb = y;         end
            6'd11: begin op = OP_ADD; aa = t_reg;     bb = y;         end // x1
            6'd12: begin op = OP_MUL; aa = kr_reg;    bb = Q_DT;      end
            6'd13: begin op = OP_SUB; aa = Q_ONE;     bb = y;         end // a
            6'd14: begin op = OP_MUL; aa = rho32;     bb = rho32;     end
            6'd15: begin op = OP_SUB; aa = Q_ONE;     bb = y;         end // omr
            6'd16: begin op = OP_MUL; aa = xi_reg;    bb = xi_reg;    end
            6'd17: begin op = OP_MUL; aa = y;         bb = omr_reg;   end
            6'd18: begin op = OP_MUL; aa = x_reg;     bb = Q_DT;      end
            6'd19: begin op = OP_MUL; aa = t_reg;     bb = y;         end // w2
            6'd20: begin op = OP_MUL; aa = a_reg;     bb = pv_reg;    end
            6'd21: begin op = OP_MUL; aa = y;         bb = a_reg;     end
            6'd22: begin op = OP_ADD; aa = t_reg;     bb = y;         end // p1
            6'd23: begin op = OP_MUL; aa = Q_HALF;    bb = Q_DT;      end
            6'd24: begin op = OP_SUB; aa = 32'sd0;    bb = y;         end // h
            6'd25: begin op = OP_MUL; aa = y;         bb = p1_reg;    end
            6'd26: begin op = OP_MUL; aa = y;         bb = h_reg;     end
            6'd27: begin op = OP_MUL; aa = x1_reg;    bb = Q_DT;      end
            6'd28: begin op = OP_ADD; aa = t_reg;     bb = y;         end // s
            6'd29: begin op = OP_MUL; aa = p1_reg;    bb = h_reg;     end // num
            6'd30: begin op = OP_MUL; aa = Q_HALF;    bb = x1_reg;    end
            6'd31: begin op = OP_SUB; aa = drift_reg; bb = y;         end
            6'd32: begin op = OP_MUL; aa = y;         bb = Q_DT;      end
            6'd33: begin op = OP_ADD; aa = prev_reg;  bb = y;         end // est
            6'd34: begin op = OP_SUB; aa = z_reg;     bb = y;         end // u
            6'd36: begin op = OP_MUL; aa = k_reg;     bb = u_reg;     end
            6'd37: begin op = OP_ADD; aa = x1_reg;    bb = y;         end // x
            6'd38: begin op = OP_MUL; aa = k_reg;     bb = h_reg;     end
            6'd39: begin op = OP_SUB; aa = Q_ONE;     bb = y;         end
            6'd40: begin op = OP_MUL; aa = y;         bb = p1_reg;    end // P
            default: begin op = OP_MUL; aa = '0; bb = '0; end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        dreq.start = 1'b0;
        dreq.num   = t2_reg;
        dreq.den   = s_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (phase_reg == 2'd2 || phase_reg == 2'd3)) begin
                    state_next = ST_CALC;
                    pc_next    = '0;
                end
            end
            ST_CALC: begin
                pc_next = pc_reg + 6'd1;
                if (pc_reg == 6'd31) begin
                    // numerator and s are ready: start the division
                    dreq.start = 1'b1;
                end
                if (pc_reg == 6'd35) begin
                    state_next = ST_DIV;
                end
                if (pc_reg == 6'd41) begin
                    state_next = ST_OUT1;
                end
            end
            ST_DIV: begin
                if (drsp.done) begin
                    state_next = ST_CALC;
                end
            end
            ST_OUT1: begin
                if (!ov_reg) begin
                    state_next = last_reg ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2: begin
                if (!ov_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // capture alu results of the previous step, the divider quotient and the input sample
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            case (pc_reg)
                6'd1:  rx_reg  <= y;
                6'd3:  kr_reg  <= y;
                6'd5:  t_reg   <= y;
                6'd9:  t_reg   <= y;
                6'd12: x1_reg  <= (y[31]) ? Q_EPS : y;
                6'd14: a_reg   <= y;
                6'd16: omr_reg <= y[31] ? 32'sd0 : y;
                6'd18: t_reg   <= y;
                6'd20: t_reg   <= y;
                6'd23: p1_reg  <= y;
                6'd25: h_reg   <= y;
                6'd27: t_reg   <= y;
                6'd29: s_reg   <= y;
                6'd30: t2_reg  <= y;
                6'd34: est_reg <= y;
                6'd35: u_reg   <= y;
                default: ;
            endcase
        end
        if (state_reg == ST_DIV && drsp.done) begin
            k_reg <= drsp.quo;
        end
        if (in_fire) begin
            z_reg    <= s_tdata;
            last_reg <= s_tlast;
            x_reg    <= xv_reg[31] ? Q_EPS : xv_reg;
        end
    end

    // architectural state, result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xv_reg <= Q_VAR0; pv_reg <= Q_P0; prev_reg <= '0; old_reg <= '0;
            pend_reg <= '0; phase_reg <= 2'd0; ov_reg <= 1'b0;
        end else begin
            if (ov_reg && m_tready) begin
                ov_reg <= 1'b0;
            end
            if (in_fire && phase_reg == 2'd0) begin
                od_reg <= {1'b0, Q_ONE[30:0], 32'd0, 32'(sat32(64'(signed'(s_tdata)) + 64'(Q_EPS)))};
                ol_reg <= s_tlast;
                ov_reg <= 1'b1;
                if (!s_tlast) begin
                    prev_reg  <= s_tdata;
                    pend_reg  <= sat32(64'(signed'(s_tdata)) + 64'(Q_EPS));
                    phase_reg <= 2'd1;
                end
            end else if (in_fire && phase_reg == 2'd1) begin
                if (s_tlast) begin
                    od_reg <= {1'b0, Q_ONE[30:0], 32'd0, pend_reg};
                    ol_reg <= 1'b1;
                    ov_reg <= 1'b1;
                    xv_reg <= Q_VAR0; pv_reg <= Q_P0; prev_reg <= '0; old_reg <= '0;
                    pend_reg <= '0; phase_reg <= 2'd0;
                end else begin
                    old_reg   <= prev_reg;
                    prev_reg  <= s_tdata;
                    phase_reg <= 2'd2;
                end
            end
            if (state_reg == ST_CALC && pc_reg == 6'd38) begin
                xv_reg <= y;
            end
            if (state_reg == ST_CALC && pc_reg == 6'd41) begin
                pv_reg <= y;
            end
            if (state_reg == ST_OUT1 && !ov_reg) begin
                od_reg <= {1'b0, (s_reg[31] ? 31'd0 : s_reg[30:0]), u_reg, pend_reg};
                ol_reg <= 1'b0;
                ov_reg <= 1'b1;
                pend_reg <= est_reg;
                if (last_reg) begin
                    xv_reg <= Q_VAR0; pv_reg <= Q_P0; prev_reg <= '0; old_reg <= '0;
                    phase_reg <= 2'd0;
                end else begin
                    old_reg  <= prev_reg;
                    prev_reg <= z_reg;
                end
            end
            if (state_reg == ST_OUT2 && !ov_reg) begin
                od_reg   <= {1'b0, Q_ONE[30:0], 32'd0, est_reg};
                ol_reg   <= 1'b1;
                ov_reg   <= 1'b1;
                pend_reg <= '0;
            end
        end
    end

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result changed");

    // no input is taken while a step runs
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready during step");

    // the divider finishes only while the sequencer waits for it
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (state_reg == ST_DIV))
        else $error("divider result lost");

endmodule

// ===== hdl/hekf_alu.sv =====
// shared Q8.24 arithmetic unit: one multiply or add/sub per cycle, registered result
// depends on hekf_pkg
module hekf_alu (
    input  logic                 aclk,
    input  hekf_pkg::alu_op_t    op,
    input  logic signed [31:0]   a,
    input  logic signed [31:0]   b,
    output logic signed [31:0]   y
);
    import hekf_pkg::*;

    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    logic signed [31:0] y_next;
    logic signed [31:0] y_reg;

    // round to nearest, ties up; arithmetic shift equals the floor form
    assign prod = a * b;
    assign rnd  = (prod + 64'sd8388608) >>> 24;

    always_comb begin
        case (op)
            OP_MUL:  y_next = sat32(rnd);
            OP_ADD:  y_next = sat32(64'(a) + 64'(b));
            OP_SUB:  y_next = sat32(64'(a) - 64'(b));
            default: y_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ===== hdl/hekf_div.sv =====
// restoring divider for the Kalman gain, one quotient bit per cycle
// depends on hekf_pkg
module hekf_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  hekf_pkg::div_req_t  req,
    output hekf_pkg::div_rsp_t  rsp
);
    import hekf_pkg::*;

    // |n|*2^24 fits in 56 bits
    logic [55:0] rem_reg,  rem_next;
    logic [55:0] quo_reg,  quo_next;
    logic [55:0] num_reg,  num_next;
    logic [31:0] den_reg,  den_next;
    logic        neg_reg,  neg_next;
    logic        zero_reg, zero_next;
    logic        nsign_reg, nsign_next;
    logic        nzero_reg, nzero_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [56:0] trial;
    logic signed [57:0] sq;
    logic [31:0] an, ad;

    assign an = req.num[31] ? 32'(-req.num) : 32'(req.num);
    assign ad = req.den[31] ? 32'(-req.den) : 32'(req.den);
    assign trial = {rem_reg, num_reg[55]} - {25'd0, den_reg};

    always_comb begin
        rem_next = rem_reg; quo_next = quo_reg; num_next = num_reg;
        den_next = den_reg; neg_next = neg_reg; zero_next = zero_reg;
        nsign_next = nsign_reg; nzero_next = nzero_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (req.start) begin
            rem_next   = '0;
            quo_next   = '0;
            num_next   = {an, 24'd0};
            den_next   = ad;
            neg_next   = req.num[31] ^ req.den[31];
            zero_next  = (req.den == 32'sd0);
            nsign_next = req.num[31];
            nzero_next = (req.num == 32'sd0);
            cnt_next   = 6'd0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // shift in one numerator bit, subtract if it fits
            if (!trial[56]) begin
                rem_next = trial[55:0];
                quo_next = {quo_reg[54:0], 1'b1};
            end else begin
                rem_next = {rem_reg[54:0], num_reg[55]};
                quo_next = {quo_reg[54:0], 1'b0};
            end
            num_next = {num_reg[54:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd55) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next; quo_reg <= quo_next; num_reg <= num_next;
        den_reg <= den_next; neg_reg <= neg_next; zero_reg <= zero_next;
        nsign_reg <= nsign_next; nzero_reg <= nzero_next;
    end

    // sign and saturation of the truncated quotient, and the result for a zero divisor
    assign sq = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    always_comb begin
        rsp.done = done_reg;
        if (zero_reg) begin
            rsp.quo = nzero_reg ? 32'sd0 : (nsign_reg ? Q_MIN : Q_MAX);
        end else begin
            rsp.quo = sat32(64'(sq));
        end
    end

endmodule
